FILE: sv/rhc_pkg.sv
// Shared types and constants for the RGB to HSV converter.
package rhc_pkg;

  // Quotient bits produced by the divider row, one per cell
  localparam int unsigned QuoW     = 15;
  // Hue remainder and numerator width: 128 * 91799 + 255 < 2**24
  localparam int unsigned HueNumW  = 24;
  // Saturation numerator width: 510 * 255 + 255 < 2**17
  localparam int unsigned SatNumW  = 17;
  // Shifted divisor width: a 9-bit divisor placed QuoW-1 bits up
  localparam int unsigned DshW     = 23;
  // 360 degrees in 1/64 degree steps, shown as zero
  localparam logic [QuoW-1:0] HueFullTurn = 15'd23040;

  // One pixel request
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  // One result
  typedef struct packed {
    logic [14:0] hue;
    logic [7:0]  saturation;
    logic [7:0]  max_level;
  } hsv_t;

  // Which component is largest (ties: red, then green)
  typedef enum logic [1:0] {
    SECT_RED,
    SECT_GREEN,
    SECT_BLUE
  } sector_e;

  // After the sort stage
  typedef struct packed {
    logic [7:0]        delta;
    logic [7:0]        max_level;
    logic signed [8:0] diff;
    sector_e           sector;
  } front_t;

  // Travelling through the divider row
  typedef struct packed {
    logic [HueNumW-1:0] hue_rem;
    logic [DshW-1:0]    hue_dsh;
    logic [QuoW-1:0]    hue_quo;
    logic [SatNumW-1:0] sat_rem;
    logic [DshW-1:0]    sat_dsh;
    logic [7:0]         sat_quo;
    logic [7:0]         max_level;
  } div_t;

endpackage

FILE: sv/rhc_front.sv
// Sort stage: largest and smallest component, sector and sector difference.
module rhc_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  rhc_pkg::rgb_t   data_i,
  output logic            stall_o,
  output logic            valid_o,
  output rhc_pkg::front_t data_o,
  input  logic            stall_i
);

  logic            valid_q;
  rhc_pkg::front_t data_q;
  rhc_pkg::front_t data_d;
  logic [7:0]      mx;
  logic [7:0]      mn;

  // Max / min and sector selection, red wins ties, then green
  always_comb begin
    mx = data_i.red;
    mn = data_i.red;
    if (data_i.green > mx) mx = data_i.green;
    if (data_i.blue > mx)  mx = data_i.blue;
    if (data_i.green < mn) mn = data_i.green;
    if (data_i.blue < mn)  mn = data_i.blue;
    data_d.max_level = mx;
    data_d.delta     = mx - mn;
    priority if (mx == data_i.red) begin
      data_d.sector = rhc_pkg::SECT_RED;
      data_d.diff   = $signed({1'b0, data_i.green}) - $signed({1'b0, data_i.blue});
    end else if (mx == data_i.green) begin
      data_d.sector = rhc_pkg::SECT_GREEN;
      data_d.diff   = $signed({1'b0, data_i.blue}) - $signed({1'b0, data_i.red});
    end else begin
      data_d.sector = rhc_pkg::SECT_BLUE;
      data_d.diff   = $signed({1'b0, data_i.red}) - $signed({1'b0, data_i.green});
    end
  end

  // Stage holds only while full and stalled downstream
  assign stall_o = valid_q && stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!stall_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

FILE: sv/rhc_prep.sv
// Numerator stage: builds hue and saturation dividends and shifted divisors.
module rhc_prep (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  rhc_pkg::front_t data_i,
  output logic            stall_o,
  output logic            valid_o,
  output rhc_pkg::div_t   data_o,
  input  logic            stall_i
);

  logic                 valid_q;
  rhc_pkg::div_t        data_q;
  rhc_pkg::div_t        data_d;
  logic [15:0]          off_mul;
  logic [16:0]          wrap_add;
  logic signed [18:0]   x_s;
  logic signed [18:0]   x_w;

  // Sector offset times delta: 0, 120 or 240 degrees
  always_comb begin
    unique case (data_i.sector)
      rhc_pkg::SECT_RED:   off_mul = 16'd0;
      rhc_pkg::SECT_GREEN: off_mul = 16'(data_i.delta) * 16'd120;
      rhc_pkg::SECT_BLUE:  off_mul = 16'(data_i.delta) * 16'd240;
      default:             off_mul = 16'd0;
    endcase
  end

  // Hue times delta in degrees, wrapped into one turn
  always_comb begin
    x_s      = $signed({3'b000, off_mul}) + 19'(data_i.diff) * 19'sd60;
    wrap_add = 17'(data_i.delta) * 17'd360;
    x_w      = x_s[18] ? x_s + $signed({2'b00, wrap_add}) : x_s;
  end

  // Dividends carry the half-step for round to nearest; a zero divisor
  // is replaced by all ones so that the quotient comes out zero
  always_comb begin
    data_d.hue_rem   = {x_w[16:0], 7'd0} + 24'(data_i.delta);
    data_d.hue_dsh   = (data_i.delta == 8'd0) ? '1 : {data_i.delta, 15'd0};
    data_d.hue_quo   = '0;
    data_d.sat_rem   = 17'(data_i.delta) * 17'd510 + 17'(data_i.max_level);
    data_d.sat_dsh   = (data_i.max_level == 8'd0) ? '1 : {data_i.max_level, 15'd0};
    data_d.sat_quo   = '0;
    data_d.max_level = data_i.max_level;
  end

  assign stall_o = valid_q && stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!stall_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

FILE: sv/rhc_div_cell.sv
// Divider cell: one restoring step for hue and saturation, divisors move down a bit.
module rhc_div_cell (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  rhc_pkg::div_t data_i,
  output logic          stall_o,
  output logic          valid_o,
  output rhc_pkg::div_t data_o,
  input  logic          stall_i
);

  logic          valid_q;
  rhc_pkg::div_t data_q;
  rhc_pkg::div_t data_d;
  logic          hue_ge;
  logic          sat_ge;

  // Trial subtract on both remainders, quotient bit in at the bottom
  always_comb begin
    hue_ge = data_i.hue_rem >= 24'(data_i.hue_dsh);
    sat_ge = 23'(data_i.sat_rem) >= data_i.sat_dsh;
    data_d.hue_rem   = hue_ge ? data_i.hue_rem - 24'(data_i.hue_dsh) : data_i.hue_rem;
    data_d.sat_rem   = sat_ge ? data_i.sat_rem - data_i.sat_dsh[16:0] : data_i.sat_rem;
    data_d.hue_quo   = {data_i.hue_quo[rhc_pkg::QuoW-2:0], hue_ge};
    data_d.sat_quo   = {data_i.sat_quo[6:0], sat_ge};
    data_d.hue_dsh   = data_i.hue_dsh >> 1;
    data_d.sat_dsh   = data_i.sat_dsh >> 1;
    data_d.max_level = data_i.max_level;
  end

  assign stall_o = valid_q && stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!stall_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

FILE: sv/rgb_to_hsv_converter_unit.sv
// Top level of the RGB to HSV converter: sort, numerators, divider row, output register.
//
// Takes one pixel request per clock while in_stall_o is low and returns hue
// (1/64 degree), saturation and value for it, in order. Each result passes 18
// registers on its way to the output: one sort stage, one numerator stage, a
// row of 15 divider cells that each settle one quotient bit of both the hue
// and the saturation division, and the output register. Every stage holds only
// while it is full and the stage after it stalls, so empty slots close up and
// the block keeps taking requests while a finished result waits to be taken,
// until every stage is full.
module rgb_to_hsv_converter_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  rhc_pkg::rgb_t in_data_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  output rhc_pkg::hsv_t out_data_o,
  input  logic          out_stall_i
);

  logic            front_valid;
  rhc_pkg::front_t front_data;
  logic            front_stall;

  logic            cell_valid [rhc_pkg::QuoW+1];
  rhc_pkg::div_t   cell_data  [rhc_pkg::QuoW+1];
  logic            cell_stall [rhc_pkg::QuoW+1];

  logic            out_valid_q;
  rhc_pkg::hsv_t   out_data_q;
  rhc_pkg::hsv_t   out_data_d;
  logic            out_hold;

  // Sort stage
  rhc_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .data_i  (in_data_i),
    .stall_o (in_stall_o),
    .valid_o (front_valid),
    .data_o  (front_data),
    .stall_i (front_stall)
  );

  // Numerator stage feeds the head of the divider row
  rhc_prep u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (front_valid),
    .data_i  (front_data),
    .stall_o (front_stall),
    .valid_o (cell_valid[0]),
    .data_o  (cell_data[0]),
    .stall_i (cell_stall[0])
  );

  // Divider row, most significant quotient bit first
  for (genvar k = 0; k < rhc_pkg::QuoW; k++) begin : g_cell
    rhc_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (cell_valid[k]),
      .data_i  (cell_data[k]),
      .stall_o (cell_stall[k]),
      .valid_o (cell_valid[k+1]),
      .data_o  (cell_data[k+1]),
      .stall_i (cell_stall[k+1])
    );
  end

  // Full turn folds back to zero
  always_comb begin
    out_data_d.hue        = (cell_data[rhc_pkg::QuoW].hue_quo == rhc_pkg::HueFullTurn)
                            ? '0 : cell_data[rhc_pkg::QuoW].hue_quo;
    out_data_d.saturation = cell_data[rhc_pkg::QuoW].sat_quo;
    out_data_d.max_level  = cell_data[rhc_pkg::QuoW].max_level;
  end

  // Output register
  assign out_hold                   = out_valid_q && out_stall_i;
  assign cell_stall[rhc_pkg::QuoW] = out_hold;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_hold) begin
      out_valid_q <= cell_valid[rhc_pkg::QuoW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_hold && cell_valid[rhc_pkg::QuoW]) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

FILE: test/tb_top.sv
// Self-checking testbench for the RGB to HSV converter unit.
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned RandomPixels = 2000;
  // No idling on either side once this few pixels remain
  localparam int unsigned QuietTail    = 250;
  localparam int unsigned ModeSpan     = 150;
  localparam int unsigned HoldOffLen   = 300;
  localparam int unsigned HoldOffAt    = 400;
  localparam int unsigned DrainCycles  = 40;
  localparam int unsigned CycleLimit   = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic          in_valid_r = 1'b0;
  rhc_pkg::rgb_t in_px_r    = '0;
  logic          in_stall;
  logic          out_valid;
  rhc_pkg::hsv_t out_hsv;
  logic          out_stall_r = 1'b0;

  rhc_pkg::rgb_t pixel_q[$];
  rhc_pkg::hsv_t hsv_expected_q[$];

  int unsigned pixels_total  = 0;
  int unsigned pixels_sent   = 0;
  int unsigned results_seen  = 0;
  int unsigned grey_seen     = 0;
  int unsigned black_seen    = 0;
  int unsigned mismatches    = 0;
  int unsigned cycles        = 0;
  int unsigned send_gap      = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_gap      = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_left     = 0;
  bit          held_off      = 1'b0;

  rgb_to_hsv_converter_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_r),
    .in_data_i   (in_px_r),
    .in_stall_o  (in_stall),
    .out_valid_o (out_valid),
    .out_data_o  (out_hsv),
    .out_stall_i (out_stall_r)
  );

  always #5 clk_i = ~clk_i;

  // Expected hue, saturation and value of one pixel, exact integer maths
  function automatic rhc_pkg::hsv_t predict_hsv(rhc_pkg::rgb_t px);
    int unsigned      r, g, b, top, bottom, spread, base, hue;
    int               diff, scaled;
    rhc_pkg::sector_e sect;
    rhc_pkg::hsv_t    res;
    r = px.red;
    g = px.green;
    b = px.blue;
    top = r;
    bottom = r;
    if (g > top) top = g;
    if (b > top) top = b;
    if (g < bottom) bottom = g;
    if (b < bottom) bottom = b;
    spread = top - bottom;
    res.max_level  = 8'(top);
    res.saturation = (top == 0) ? 8'd0 : 8'((510 * spread + top) / (2 * top));
    if (spread == 0) begin
      hue = 0;
    end else begin
      // largest component picks the sector, ties go to red then green
      if (top == r) sect = rhc_pkg::SECT_RED;
      else if (top == g) sect = rhc_pkg::SECT_GREEN;
      else sect = rhc_pkg::SECT_BLUE;
      case (sect)
        rhc_pkg::SECT_RED: begin
          base = 0;
          diff = int'(g) - int'(b);
        end
        rhc_pkg::SECT_GREEN: begin
          base = 120;
          diff = int'(b) - int'(r);
        end
        default: begin
          base = 240;
          diff = int'(r) - int'(g);
        end
      endcase
      scaled = int'(base * spread) + 60 * diff;
      if (scaled < 0) scaled += int'(360 * spread);
      hue = (128 * int'(scaled) + spread) / (2 * spread);
      if (hue >= rhc_pkg::HueFullTurn) hue = 0;
    end
    res.hue = 15'(hue);
    return res;
  endfunction

  function automatic rhc_pkg::rgb_t make_px(int unsigned r, int unsigned g, int unsigned b);
    rhc_pkg::rgb_t px;
    px.red   = 8'(r);
    px.green = 8'(g);
    px.blue  = 8'(b);
    return px;
  endfunction

  // Appends one pixel to the pending queue
  task automatic add_px(rhc_pkg::rgb_t px);
    pixel_q = {pixel_q, px};
  endtask

  // Random pixel: uniform, near grey, one component pinned to a rail, or a tie on the largest
  function automatic rhc_pkg::rgb_t random_px();
    int unsigned   kind, base;
    rhc_pkg::rgb_t px;
    kind = $urandom_range(9);
    px = make_px($urandom_range(255), $urandom_range(255), $urandom_range(255));
    if (kind < 2) begin
      base = $urandom_range(255);
      px = make_px(base, base ^ $urandom_range(3), base ^ $urandom_range(3));
    end else if (kind == 2) begin
      px.red = $urandom_range(1) ? 8'hff : 8'h00;
    end else if (kind == 3) begin
      px.green = $urandom_range(1) ? 8'hff : 8'h00;
    end else if (kind == 4) begin
      px.blue = $urandom_range(1) ? 8'hff : 8'h00;
    end else if (kind == 5) begin
      // two-way tie on the largest component
      base = $urandom_range(255);
      case ($urandom_range(2))
        0: px = make_px(base, base, $urandom_range(base));
        1: px = make_px(base, $urandom_range(base), base);
        default: px = make_px($urandom_range(base), base, base);
      endcase
    end
    return px;
  endfunction

  // Driver: offers pixels from pixel_q, idles in random bursts
  always @(posedge clk_i) begin
    logic          next_valid;
    rhc_pkg::rgb_t next_px;
    if (rst_ni) begin
      next_valid = in_valid_r;
      next_px = in_px_r;
      if (in_valid_r && !in_stall) begin
        hsv_expected_q = {hsv_expected_q, predict_hsv(in_px_r)};
        pixels_sent++;
        next_valid = 1'b0;
        if (pixels_sent % ModeSpan == 0) begin
          case ($urandom_range(2))
            0: send_idle_pct = 0;
            1: send_idle_pct = 10;
            default: send_idle_pct = 40;
          endcase
        end
      end
      if (!next_valid) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pixel_q.size() != 0) begin
          if (send_idle_pct != 0 && pixel_q.size() > QuietTail &&
              $urandom_range(99) < send_idle_pct) begin
            send_gap = $urandom_range(19, 1) - 1;
          end else begin
            next_valid = 1'b1;
            next_px = pixel_q.pop_front();
          end
        end
      end
      in_valid_r <= next_valid;
      in_px_r <= next_px;
    end
  end

  // Receiver: random stall bursts plus one long hold-off
  always @(posedge clk_i) begin
    logic next_stall;
    if (rst_ni) begin
      next_stall = 1'b0;
      if (!held_off && results_seen >= HoldOffAt) begin
        held_off = 1'b1;
        hold_left = HoldOffLen;
      end
      if (hold_left > 0) begin
        hold_left--;
        next_stall = 1'b1;
      end else if (recv_gap > 0) begin
        recv_gap--;
        next_stall = 1'b1;
      end else if (recv_idle_pct != 0 && results_seen + QuietTail < pixels_total &&
                   $urandom_range(99) < recv_idle_pct) begin
        recv_gap = $urandom_range(19, 1) - 1;
        next_stall = 1'b1;
      end
      out_stall_r <= next_stall;
    end
  end

  // Monitor: checks each result against the oldest prediction
  always @(posedge clk_i) begin
    rhc_pkg::hsv_t want;
    if (rst_ni && out_valid && !out_stall_r) begin
      results_seen++;
      if (results_seen % ModeSpan == 0) recv_idle_pct = $urandom_range(2) * 20;
      if (hsv_expected_q.size() == 0) begin
        $error("result with no pixel outstanding: hue %0d sat %0d val %0d",
               out_hsv.hue, out_hsv.saturation, out_hsv.max_level);
        mismatches++;
      end else begin
        want = hsv_expected_q.pop_front();
        if (want.max_level == want.saturation * 0) black_seen += (want.max_level == 0);
        if (want.saturation == 0) grey_seen++;
        if (out_hsv.hue !== want.hue) begin
          $error("hue: expected %0d, actual %0d", want.hue, out_hsv.hue);
          mismatches++;
        end
        if (out_hsv.saturation !== want.saturation) begin
          $error("saturation: expected %0d, actual %0d", want.saturation,
                 out_hsv.saturation);
          mismatches++;
        end
        if (out_hsv.max_level !== want.max_level) begin
          $error("max_level: expected %0d, actual %0d", want.max_level,
                 out_hsv.max_level);
          mismatches++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               hsv_expected_q.size());
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    // directed: rails, greys, pure colours, ties, wrap and rounding cases
    add_px(make_px(0, 0, 0));
    add_px(make_px(255, 255, 255));
    add_px(make_px(128, 128, 128));
    add_px(make_px(1, 1, 1));
    add_px(make_px(255, 0, 0));
    add_px(make_px(0, 255, 0));
    add_px(make_px(0, 0, 255));
    add_px(make_px(1, 0, 0));
    add_px(make_px(0, 1, 0));
    add_px(make_px(0, 0, 1));
    add_px(make_px(255, 255, 0));
    add_px(make_px(255, 0, 255));
    add_px(make_px(0, 255, 255));
    add_px(make_px(255, 0, 1));
    add_px(make_px(255, 254, 255));
    add_px(make_px(254, 255, 255));
    add_px(make_px(2, 1, 1));
    add_px(make_px(3, 1, 2));
    add_px(make_px(255, 1, 0));
    add_px(make_px(1, 255, 0));
    add_px(make_px(0, 1, 255));
    add_px(make_px(170, 85, 0));
    add_px(make_px(85, 170, 255));
    for (int unsigned i = 0; i < RandomPixels; i++) add_px(random_px());
    pixels_total = pixel_q.size();

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pixel_q.size() != 0 || in_valid_r || hsv_expected_q.size() != 0)
      @(negedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("converted %0d of %0d pixels (%0d grey, %0d black), with idling on both sides",
             results_seen, pixels_sent, grey_seen, black_seen);
    $display("and one %0d-cycle output hold-off to back the pipeline up", HoldOffLen);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
sv/rhc_pkg.sv
sv/rhc_front.sv
sv/rhc_prep.sv
sv/rhc_div_cell.sv
sv/rgb_to_hsv_converter_unit.sv
test/tb_top.sv
